### hdl/afe_pkg.sv
`default_nettype none
package afe_pkg;

    // field and state widths
    localparam int RAW_W      = 32;
    localparam int SHIFT_R    = 14;
    localparam int SAMPLE_W   = 18;
    localparam int SQ_W       = 46;
    localparam int SQTERM_W   = 35;
    localparam int MAG_SUM_W  = 30;
    localparam int HPE_W      = 58;
    localparam int HPY_W      = 32;
    localparam int PROD_W     = 49;
    localparam int CNT_W      = 13;
    localparam int ALPHA_W    = 15;
    localparam int THR_W      = 18;
    localparam int LIM_W      = 8;
    localparam int RMS_W      = 26;
    localparam int MEAN_W     = 26;
    localparam int Q16_W      = 17;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 18;
    localparam logic [CFG_IDX_W-1:0] CFG_HP_ALPHA  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_THR  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LIM  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LIM  = 8'd3;

    localparam logic [ALPHA_W-1:0] ALPHA_RST    = 15'd29491;
    localparam logic [THR_W-1:0]   CLIP_THR_RST = 18'd130000;
    localparam logic [LIM_W-1:0]   ZERO_LIM_RST = 8'd10;
    localparam logic [LIM_W-1:0]   CLIP_LIM_RST = 8'd10;

    localparam int MAX_FRAME_DEF = 512;

    // serial divider and square root
    localparam int DIV_N_W    = 66;
    localparam int DIV_D_W    = 46;
    localparam int DIV_CNT_W  = 7;
    localparam int SQRT_IN_W  = 62;
    localparam int SQRT_OUT_W = 31;
    localparam int SQRT_CNT_W = 5;

    // end-of-frame division select
    localparam logic [1:0] DSEL_SQ    = 2'd0;
    localparam logic [1:0] DSEL_MEAN  = 2'd1;
    localparam logic [1:0] DSEL_ZCR   = 2'd2;
    localparam logic [1:0] DSEL_RATIO = 2'd3;

    typedef struct packed {
        logic signed [RAW_W-1:0] raw_word;
        logic                    last_of_frame;
    } t_in;

    typedef struct packed {
        logic [RMS_W-1:0]  rms_q8;
        logic [THR_W-1:0]  peak_magnitude;
        logic [MEAN_W-1:0] mean_abs_q8;
        logic [Q16_W-1:0]  zero_cross_rate_q16;
        logic [Q16_W-1:0]  high_freq_ratio_q16;
        logic              mic_ok;
    } t_out;

    typedef struct packed {
        logic       take;
        logic       mul;
        logic       acc;
        logic       hpe;
        logic       div_start;
        logic [1:0] div_sel;
        logic       sqrt_start;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic frame_end;
        logic div_done;
        logic sqrt_done;
        logic out_busy;
    } t_sts;

endpackage
`default_nettype wire

### hdl/audio_frame_feature_extractor.sv
`default_nettype none
// Frame feature extractor for microphone capture words. Each accepted word
// passes through accept, two multiplier stages and energy accumulate; input
// ready is low until all of these are done. On the frame's last sample (or when
// MAX_FRAME samples have been taken) the block runs four 66-step serial
// divisions and a 31-step square root, then loads one result into the output
// register. New samples are taken while a result waits on the output; a second
// result waits until the first has been transferred.
module audio_frame_feature_extractor
    import afe_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output t_out                 o_out_data,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    afe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_ready (o_in_ready)
    );

    afe_dpath #(
        .MAX_FRAME (MAX_FRAME)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (o_out_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

endmodule
`default_nettype wire

### hdl/afe_div.sv
`default_nettype none
module afe_div
    import afe_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire [DIV_N_W-1:0]   i_dividend,
    input  wire [DIV_D_W-1:0]   i_divisor,
    output logic [DIV_N_W-1:0]  o_quotient,
    output logic                o_done
);

    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_N_W-1:0]   r_quo;
    logic [DIV_D_W-1:0]   r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_D_W:0]     w_sh;
    logic                 w_ge;
    logic [DIV_D_W:0]     w_diff;

    // one quotient bit per cycle, restoring
    assign w_sh   = {r_rem, r_quo[DIV_N_W-1]};
    assign w_ge   = w_sh >= {1'b0, r_div};
    assign w_diff = w_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operand and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_D_W-1:0] : w_sh[DIV_D_W-1:0];
            r_quo <= {r_quo[DIV_N_W-2:0], w_ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule
`default_nettype wire

### hdl/afe_sqrt.sv
`default_nettype none
module afe_sqrt
    import afe_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  wire [SQRT_IN_W-1:0]   i_radicand,
    output logic [SQRT_OUT_W-1:0] o_root,
    output logic                  o_done
);

    logic [SQRT_IN_W-1:0]  r_v;
    logic [SQRT_IN_W-1:0]  r_res;
    logic [SQRT_IN_W-1:0]  r_bit;
    logic [SQRT_CNT_W-1:0] r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [SQRT_IN_W-1:0]  w_trial;

    // two radicand bits per cycle, one root bit
    assign w_trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == SQRT_CNT_W'(SQRT_OUT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_radicand;
            r_res <= '0;
            r_bit <= SQRT_IN_W'(1) << (SQRT_IN_W - 2);
        end else if (r_busy) begin
            if (r_v >= w_trial) begin
                r_v   <= r_v - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_root = r_res[SQRT_OUT_W-1:0];
    assign o_done = r_done;

endmodule
`default_nettype wire

### hdl/afe_ctrl.sv
`default_nettype none
module afe_ctrl
    import afe_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    input  t_sts  i_sts,
    output t_cmd  o_cmd,
    output logic  o_in_ready
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_MUL       = 4'd1;
    localparam logic [3:0] S_ACC       = 4'd2;
    localparam logic [3:0] S_HPE       = 4'd3;
    localparam logic [3:0] S_DIV_GO    = 4'd4;
    localparam logic [3:0] S_DIV_WAIT  = 4'd5;
    localparam logic [3:0] S_SQRT_GO   = 4'd6;
    localparam logic [3:0] S_SQRT_WAIT = 4'd7;
    localparam logic [3:0] S_EMIT      = 4'd8;

    logic [3:0] r_state, n_state;
    logic [1:0] r_sel, n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= DSEL_SQ;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        o_cmd   = '0;
        o_cmd.div_sel = r_sel;
        case (r_state)
            S_IDLE: begin
                o_cmd.take = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_HPE;
            end
            S_HPE: begin
                o_cmd.hpe = 1'b1;
                n_sel     = DSEL_SQ;
                n_state   = i_sts.frame_end ? S_DIV_GO : S_IDLE;
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    if (r_sel == DSEL_RATIO) begin
                        n_state = S_SQRT_GO;
                    end else begin
                        n_sel   = r_sel + 1'b1;
                        n_state = S_DIV_GO;
                    end
                end
            end
            S_SQRT_GO: begin
                o_cmd.sqrt_start = 1'b1;
                n_state          = S_SQRT_WAIT;
            end
            S_SQRT_WAIT: begin
                if (i_sts.sqrt_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

`ifndef ASSERT_OFF
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> !i_sts.out_busy)
        else $error("result loaded while output register still held");
    a_div_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_WAIT && i_sts.div_done) |=>
        (r_state == S_DIV_GO || r_state == S_SQRT_GO))
        else $error("division finish not followed by next unit start");
    a_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HPE && !i_sts.frame_end) |=> o_in_ready)
        else $error("mid-frame sample did not return to idle");
`endif

endmodule
`default_nettype wire

### hdl/afe_dpath.sv
`default_nettype none
module afe_dpath
    import afe_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  t_in                   i_in_data,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    output t_out                  o_out_data,
    output logic                  o_out_valid,
    input  wire                   i_out_ready
);

    // configuration
    logic [ALPHA_W-1:0] r_alpha;
    logic [THR_W-1:0]   r_thr;
    logic [LIM_W-1:0]   r_zlim;
    logic [LIM_W-1:0]   r_clim;

    // sample and products
    logic signed [SAMPLE_W-1:0] r_s;
    logic                       r_last;
    logic [SQTERM_W-1:0]        r_sq;
    logic signed [PROD_W-1:0]   r_prod;
    logic [63:0]                r_ysq;

    // frame accumulators
    logic [SQ_W-1:0]      r_ss;
    logic [MAG_SUM_W-1:0] r_msum;
    logic [HPE_W-1:0]     r_hpe;
    logic [THR_W-1:0]     r_peak;
    logic [CNT_W-1:0]     r_cross;
    logic [CNT_W-1:0]     r_cnt;

    // state across frames
    logic                       r_prev_nn;
    logic signed [SAMPLE_W-1:0] r_hp_in;
    logic signed [HPY_W-1:0]    r_hp_out;
    logic [LIM_W-1:0]           r_silent;
    logic [LIM_W-1:0]           r_clipped;

    // end-of-frame results
    logic [1:0]            r_sel;
    logic [SQRT_IN_W-1:0]  r_msq;
    logic [MEAN_W-1:0]     r_mean;
    logic [Q16_W-1:0]      r_zcr;
    logic [Q16_W-1:0]      r_ratio;
    logic [SQRT_OUT_W-1:0] r_rms;
    t_out                  r_out;
    logic                  r_out_valid;

    logic [DIV_N_W-1:0]    w_dividend;
    logic [DIV_D_W-1:0]    w_divisor;
    logic [DIV_N_W-1:0]    w_quo;
    logic                  w_div_done;
    logic [SQRT_OUT_W-1:0] w_root;
    logic                  w_sqrt_done;
    logic [CNT_W-1:0]      w_n_minus1;

    logic signed [SAMPLE_W:0]   w_dx;
    logic signed [32:0]         w_t;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [PROD_W:0]     w_rnd;
    logic signed [34:0]         w_ysh;
    logic signed [HPY_W-1:0]    w_y;
    logic signed [63:0]         w_ysq;
    logic signed [35:0]         w_sq;
    logic [SAMPLE_W-1:0]        w_mag;
    logic                       w_nonneg;
    logic [SQ_W:0]              w_ss_sum;
    logic [HPE_W:0]             w_hpe_sum;

    logic                 w_silent;
    logic                 w_clip;
    logic [LIM_W-1:0]     w_silent_n;
    logic [LIM_W-1:0]     w_clipped_n;
    logic [Q16_W-1:0]     w_ratio_out;
    logic [Q16_W-1:0]     w_zcr_out;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RST;
            r_thr   <= CLIP_THR_RST;
            r_zlim  <= ZERO_LIM_RST;
            r_clim  <= CLIP_LIM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HP_ALPHA: r_alpha <= i_cfg_data[ALPHA_W-1:0];
                CFG_CLIP_THR: r_thr   <= i_cfg_data[THR_W-1:0];
                CFG_ZERO_LIM: r_zlim  <= i_cfg_data[LIM_W-1:0];
                CFG_CLIP_LIM: r_clim  <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // filter input step and rounding
    assign w_dx   = {r_s[SAMPLE_W-1], r_s} - {r_hp_in[SAMPLE_W-1], r_hp_in};
    assign w_t    = {r_hp_out[HPY_W-1], r_hp_out}
                  + $signed({{2{w_dx[SAMPLE_W]}}, w_dx, 12'd0});
    assign w_prod = w_t * $signed({1'b0, r_alpha});
    assign w_sq   = r_s * r_s;
    assign w_rnd  = {r_prod[PROD_W-1], r_prod} + (PROD_W+1)'(16384);
    assign w_ysh  = $signed(w_rnd[PROD_W:15]);

    // saturate filter output to 32 bits
    always_comb begin
        if (w_ysh[34:31] == 4'b0000 || w_ysh[34:31] == 4'b1111) begin
            w_y = w_ysh[HPY_W-1:0];
        end else if (w_ysh[34]) begin
            w_y = {1'b1, {(HPY_W-1){1'b0}}};
        end else begin
            w_y = {1'b0, {(HPY_W-1){1'b1}}};
        end
    end

    assign w_ysq     = w_y * w_y;
    assign w_mag     = r_s[SAMPLE_W-1] ? SAMPLE_W'(-r_s) : SAMPLE_W'(r_s);
    assign w_nonneg  = !r_s[SAMPLE_W-1];
    assign w_ss_sum  = {1'b0, r_ss} + (SQ_W+1)'(r_sq);
    assign w_hpe_sum = {1'b0, r_hpe} + (HPE_W+1)'(r_ysq[63:16]);

    // per-sample path
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_s    <= i_in_data.raw_word[RAW_W-1:SHIFT_R];
            r_last <= i_in_data.last_of_frame;
        end
        if (i_cmd.mul) begin
            r_sq   <= w_sq[SQTERM_W-1:0];
            r_prod <= w_prod;
        end
        if (i_cmd.acc) begin
            r_ysq <= w_ysq;
        end
    end

    // accumulators and filter memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ss      <= '0;
            r_msum    <= '0;
            r_hpe     <= '0;
            r_peak    <= '0;
            r_cross   <= '0;
            r_cnt     <= '0;
            r_prev_nn <= 1'b0;
            r_hp_in   <= '0;
            r_hp_out  <= '0;
            r_silent  <= '0;
            r_clipped <= '0;
        end else if (i_cmd.acc) begin
            r_ss   <= w_ss_sum[SQ_W] ? {SQ_W{1'b1}} : w_ss_sum[SQ_W-1:0];
            r_msum <= r_msum + MAG_SUM_W'(w_mag);
            if (w_mag > r_peak) begin
                r_peak <= w_mag;
            end
            if (r_cnt != '0 && w_nonneg != r_prev_nn) begin
                r_cross <= r_cross + 1'b1;
            end
            r_prev_nn <= w_nonneg;
            r_cnt     <= r_cnt + 1'b1;
            r_hp_in   <= r_s;
            r_hp_out  <= w_y;
        end else if (i_cmd.hpe) begin
            r_hpe <= w_hpe_sum[HPE_W] ? {HPE_W{1'b1}} : w_hpe_sum[HPE_W-1:0];
        end else if (i_cmd.emit) begin
            r_silent  <= w_silent_n;
            r_clipped <= w_clipped_n;
            r_ss      <= '0;
            r_msum    <= '0;
            r_hpe     <= '0;
            r_peak    <= '0;
            r_cross   <= '0;
            r_cnt     <= '0;
        end
    end

    // division operands
    assign w_n_minus1 = r_cnt - 1'b1;

    always_comb begin
        case (i_cmd.div_sel)
            DSEL_SQ: begin
                w_dividend = DIV_N_W'({r_ss, 16'd0});
                w_divisor  = DIV_D_W'(r_cnt);
            end
            DSEL_MEAN: begin
                w_dividend = DIV_N_W'({r_msum, 8'd0});
                w_divisor  = DIV_D_W'(r_cnt);
            end
            DSEL_ZCR: begin
                w_dividend = DIV_N_W'({r_cross, 16'd0});
                w_divisor  = DIV_D_W'(w_n_minus1);
            end
            DSEL_RATIO: begin
                w_dividend = {r_hpe, 8'd0};
                w_divisor  = r_ss;
            end
            default: begin
                w_dividend = '0;
                w_divisor  = '0;
            end
        endcase
    end

    afe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    afe_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sqrt_start),
        .i_radicand (r_msq),
        .o_root     (w_root),
        .o_done     (w_sqrt_done)
    );

    // capture unit results
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_sel <= i_cmd.div_sel;
        end
        if (w_div_done) begin
            case (r_sel)
                DSEL_SQ:    r_msq   <= w_quo[SQRT_IN_W-1:0];
                DSEL_MEAN:  r_mean  <= w_quo[MEAN_W-1:0];
                DSEL_ZCR:   r_zcr   <= w_quo[Q16_W-1:0];
                DSEL_RATIO: r_ratio <= w_quo[Q16_W-1:0];
                default: ;
            endcase
        end
        if (w_sqrt_done) begin
            r_rms <= w_root;
        end
    end

    // streaks and special cases at frame end
    assign w_silent = {r_ss, 2'b00} <= (SQ_W+2)'(r_cnt);
    assign w_clip   = r_peak >= r_thr;

    always_comb begin
        if (w_silent) begin
            w_silent_n = (r_silent == {LIM_W{1'b1}}) ? r_silent : r_silent + 1'b1;
        end else begin
            w_silent_n = '0;
        end
        if (w_clip) begin
            w_clipped_n = (r_clipped == {LIM_W{1'b1}}) ? r_clipped : r_clipped + 1'b1;
        end else begin
            w_clipped_n = '0;
        end
        if (r_ss == '0) begin
            w_ratio_out = (r_hpe != '0) ? Q16_W'(65536) : '0;
        end else if (r_hpe >= HPE_W'({r_ss, 8'd0})) begin
            w_ratio_out = Q16_W'(65536);
        end else begin
            w_ratio_out = r_ratio;
        end
        w_zcr_out = (r_cnt == CNT_W'(1)) ? '0 : r_zcr;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.rms_q8              <= r_rms[RMS_W-1:0];
            r_out.peak_magnitude      <= r_peak;
            r_out.mean_abs_q8         <= r_mean;
            r_out.zero_cross_rate_q16 <= w_zcr_out;
            r_out.high_freq_ratio_q16 <= w_ratio_out;
            r_out.mic_ok              <= (w_silent_n < r_zlim) && (w_clipped_n < r_clim);
        end
    end

    assign o_out_data      = r_out;
    assign o_out_valid     = r_out_valid;
    assign o_sts.frame_end = r_last || (r_cnt == CNT_W'(MAX_FRAME));
    assign o_sts.div_done  = w_div_done;
    assign o_sts.sqrt_done = w_sqrt_done;
    assign o_sts.out_busy  = r_out_valid && !i_out_ready;

endmodule
`default_nettype wire

### tb/sv/audio_frame_feature_extractor_tb.sv
`timescale 1ns / 100ps
module audio_frame_feature_extractor_tb;
    import afe_pkg::*;

    localparam int                     FRAME_CAP   = MAX_FRAME_DEF;
    localparam int                     SETTLE_CYC  = 450;
    localparam int                     CYCLE_LIMIT = 3000000;
    localparam longint unsigned        SQ_SAT      = (64'd1 << SQ_W) - 1;
    localparam longint unsigned        HPE_SAT     = (64'd1 << HPE_W) - 1;

    // frame content styles for the random part
    typedef enum int {FRAME_NOISE, FRAME_SILENT, FRAME_LOUD, FRAME_QUIET} t_frame_style;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in                   i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out                  o_out_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    audio_frame_feature_extractor uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // feature model state
    logic [ALPHA_W-1:0] alpha_q15;
    logic [THR_W-1:0]   clip_thr;
    logic [LIM_W-1:0]   zero_lim;
    logic [LIM_W-1:0]   clip_lim;
    longint unsigned    sq_acc;
    logic [MAG_SUM_W-1:0] mag_acc;
    longint unsigned    hp_energy_acc;
    longint unsigned    peak_acc;
    int unsigned        cross_cnt;
    int unsigned        sample_cnt;
    bit                 last_nonneg;
    longint             hp_last_x;
    longint             hp_last_y;
    int unsigned        silent_run;
    int unsigned        clip_run;

    t_out               frame_results_q[$];
    int                 error_cnt;
    int                 cycle_cnt;
    bit                 no_idle;

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   -= res + bitv;
                res  = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // one accepted sample: update accumulators, queue a result at frame end
    task automatic predict_sample(input t_in d);
        longint          s;
        longint          t;
        longint          y;
        longint unsigned mag;
        longint unsigned n;
        longint unsigned ratio;
        t_out            r;
        s   = longint'($signed(d.raw_word)) >>> SHIFT_R;
        mag = (s < 0) ? -s : s;
        sq_acc += longint'(s * s);
        if (sq_acc > SQ_SAT) sq_acc = SQ_SAT;
        mag_acc = mag_acc + mag[MAG_SUM_W-1:0];
        if (mag > peak_acc) peak_acc = mag;
        if (sample_cnt > 0 && (s >= 0) != last_nonneg) cross_cnt++;
        last_nonneg = (s >= 0);
        sample_cnt++;
        // high-pass filter in Q12, round half up, saturate to 32 bits
        t = hp_last_y + (s - hp_last_x) * 4096;
        y = (t * longint'(alpha_q15) + 16384) >>> 15;
        if (y > 64'sd2147483647) y = 64'sd2147483647;
        if (y < -64'sd2147483648) y = -64'sd2147483648;
        hp_last_x = s;
        hp_last_y = y;
        hp_energy_acc += longint'(y * y) >> 16;
        if (hp_energy_acc > HPE_SAT) hp_energy_acc = HPE_SAT;
        if (!d.last_of_frame && sample_cnt < FRAME_CAP) return;

        n = sample_cnt;
        if (sq_acc == 0) ratio = (hp_energy_acc != 0) ? 65536 : 0;
        else if (hp_energy_acc >= (sq_acc << 8)) ratio = 65536;
        else ratio = (hp_energy_acc << 8) / sq_acc;
        if (4 * sq_acc <= n) begin
            if (silent_run < 255) silent_run++;
        end else begin
            silent_run = 0;
        end
        if (peak_acc >= clip_thr) begin
            if (clip_run < 255) clip_run++;
        end else begin
            clip_run = 0;
        end
        r.rms_q8              = RMS_W'(floor_sqrt((sq_acc << 16) / n));
        r.peak_magnitude      = THR_W'(peak_acc);
        r.mean_abs_q8         = MEAN_W'((longint'(mag_acc) << 8) / n);
        r.zero_cross_rate_q16 = Q16_W'((n > 1) ? (longint'(cross_cnt) << 16) / (n - 1) : 0);
        r.high_freq_ratio_q16 = Q16_W'(ratio);
        r.mic_ok              = (silent_run < zero_lim) && (clip_run < clip_lim);
        frame_results_q.push_back(r);
        sq_acc        = 0;
        mag_acc       = '0;
        hp_energy_acc = 0;
        peak_acc      = 0;
        cross_cnt     = 0;
        sample_cnt    = 0;
    endtask

    // register write, one per clock
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        case (idx)
            CFG_HP_ALPHA: alpha_q15 = val[ALPHA_W-1:0];
            CFG_CLIP_THR: clip_thr  = val[THR_W-1:0];
            CFG_ZERO_LIM: zero_lim  = val[LIM_W-1:0];
            CFG_CLIP_LIM: clip_lim  = val[LIM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic cfg_all(input int unsigned a, input int unsigned thr,
                           input int unsigned zl, input int unsigned cl);
        i_in_valid <= 1'b0;
        while (frame_results_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        cfg_write(CFG_HP_ALPHA, a);
        cfg_write(CFG_CLIP_THR, thr);
        cfg_write(CFG_ZERO_LIM, zl);
        cfg_write(CFG_CLIP_LIM, cl);
        i_cfg_we <= 1'b0;
    endtask

    // drive one sample, wait for its transfer
    task automatic send_sample(input logic [RAW_W-1:0] raw, input bit last);
        t_in d;
        d.raw_word      = raw;
        d.last_of_frame = last;
        while (!no_idle && $urandom_range(99) < 7) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= d;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_sample(d);
    endtask

    function automatic logic [RAW_W-1:0] make_word(input t_frame_style st);
        logic [RAW_W-1:0] w;
        case (st)
            FRAME_SILENT: w = $urandom_range(16383);
            FRAME_LOUD: w = $urandom_range(1) ? 32'h8000_0000 + $urandom_range(1 << 22)
                                              : 32'h7FFF_FFFF - $urandom_range(1 << 22);
            FRAME_QUIET: w = ((int'($urandom_range(2000)) - 1000) <<< SHIFT_R)
                             | $urandom_range(16383);
            default: w = $urandom;
        endcase
        return w;
    endfunction

    task automatic send_frame(input t_frame_style st, input int len);
        for (int k = 0; k < len; k++) send_sample(make_word(st), k == len - 1);
    endtask

    task automatic random_frames(input int items);
        int           sent;
        int           len;
        t_frame_style st;
        sent = 0;
        while (sent < items) begin
            st  = t_frame_style'($urandom_range(3));
            len = $urandom_range(1, 12);
            send_frame(st, len);
            sent += len;
        end
    endtask

    // directed rows
    typedef struct {
        logic [RAW_W-1:0] raw;
        bit               last;
        bit               typed;
        t_out             want;
    } t_row;

    t_row directed_rows[$] = '{
        '{32'h0000_0000, 1, 1, '{0, 0, 0, 0, 0, 1}},
        '{32'h7FFF_FFFF, 1, 0, '0},
        '{32'h8000_0000, 1, 0, '0},
        '{32'h0000_3FFF, 0, 0, '0},
        '{32'hFFFF_FFFF, 0, 0, '0},
        '{32'h0000_4000, 0, 0, '0},
        '{32'hFFFF_C000, 1, 0, '0},
        '{32'h1234_5678, 0, 0, '0},
        '{32'hEDCB_A987, 1, 0, '0},
        '{32'h7FFF_FFFF, 0, 0, '0},
        '{32'h8000_0000, 1, 0, '0},
        '{32'h0000_0000, 1, 0, '0},
        '{32'h0000_0000, 0, 0, '0},
        '{32'h0000_1234, 0, 0, '0},
        '{32'h0000_0000, 1, 0, '0},
        '{32'h5555_5555, 0, 0, '0},
        '{32'hAAAA_AAAA, 1, 0, '0}
    };

    task automatic field_check(input string fname, input longint unsigned want,
                               input longint unsigned got);
        if (want !== got) begin
            $display("%0t mismatch %s expected %0d actual %0d", $time, fname, want, got);
            error_cnt++;
        end
    endtask

    // result side: random stalls, compare each transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (frame_results_q.size() == 0) begin
                $display("%0t unexpected result, actual %h", $time, o_out_data);
                error_cnt++;
            end else begin
                want = frame_results_q.pop_front();
                field_check("rms_q8", want.rms_q8, o_out_data.rms_q8);
                field_check("peak_magnitude", want.peak_magnitude, o_out_data.peak_magnitude);
                field_check("mean_abs_q8", want.mean_abs_q8, o_out_data.mean_abs_q8);
                field_check("zero_cross_rate_q16", want.zero_cross_rate_q16,
                            o_out_data.zero_cross_rate_q16);
                field_check("high_freq_ratio_q16", want.high_freq_ratio_q16,
                            o_out_data.high_freq_ratio_q16);
                field_check("mic_ok", want.mic_ok, o_out_data.mic_ok);
            end
        end
        i_out_ready <= no_idle || ($urandom_range(99) >= 7);
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_out_ready   = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        error_cnt     = 0;
        cycle_cnt     = 0;
        no_idle       = 0;
        alpha_q15     = ALPHA_RST;
        clip_thr      = CLIP_THR_RST;
        zero_lim      = ZERO_LIM_RST;
        clip_lim      = CLIP_LIM_RST;
        sq_acc        = 0;
        mag_acc       = '0;
        hp_energy_acc = 0;
        peak_acc      = 0;
        cross_cnt     = 0;
        sample_cnt    = 0;
        last_nonneg   = 0;
        hp_last_x     = 0;
        hp_last_y     = 0;
        silent_run    = 0;
        clip_run      = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows, typed rows replace the model value in the queue
        foreach (directed_rows[i]) begin
            send_sample(directed_rows[i].raw, directed_rows[i].last);
            if (directed_rows[i].typed) begin
                void'(frame_results_q.pop_back());
                frame_results_q.push_back(directed_rows[i].want);
            end
        end
        random_frames(30);

        // no filter, everything clipped, limits of one
        cfg_all(0, 0, 1, 1);
        random_frames(30);

        // full alpha, clipping impossible, widest limits, no idling,
        // run of silent frames to build up the streak counter
        cfg_all(32767, 18'h3FFFF, 255, 255);
        no_idle = 1;
        for (int k = 0; k < 20; k++) send_frame(FRAME_SILENT, 1);
        random_frames(10);
        no_idle = 0;

        // limit zero
        cfg_all($urandom_range(32767), 131072, 0, 0);
        random_frames(20);

        // frame overflow without last flag, threshold at top of range
        cfg_all($urandom_range(32767), 131072, $urandom_range(1, 255), $urandom_range(1, 255));
        send_frame(FRAME_QUIET, 515);
        random_frames(20);

        cfg_all($urandom_range(32767), $urandom_range(131072), $urandom_range(1, 4),
                $urandom_range(1, 4));
        random_frames(20);

        i_in_valid <= 1'b0;
        while (frame_results_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (error_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
